/* design/nfaea_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfaea_pkg
// Shared constants, codes and types of the epsilon-NFA acceptor.
// ----------------------------------------------------------------------------
package nfaea_pkg;

  // automaton size
  localparam int NUM_STATES  = 16;
  localparam int NUM_SYMBOLS = 16;

  // fixed field widths
  localparam int SET_W     = 16;
  localparam int ST_IDX_W  = 4;
  localparam int SYM_IDX_W = 4;
  localparam int CMD_W     = 2;

  // states that can hold a bit in the active set
  localparam int LIVE_STATES = (NUM_STATES < SET_W) ? NUM_STATES : SET_W;
  localparam logic [SET_W-1:0] STATE_MASK = SET_W'((33'd1 << LIVE_STATES) - 33'd1);

  localparam int CNT_W = $clog2(LIVE_STATES);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(LIVE_STATES - 1);

  // table storage
  localparam int SYM_DEPTH = NUM_STATES * NUM_SYMBOLS;
  localparam int SYM_AW    = $clog2(SYM_DEPTH);
  localparam int EPS_DEPTH = NUM_STATES;
  localparam int EPS_AW    = $clog2(EPS_DEPTH);

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = SET_W;
  localparam logic [CFG_IDX_W-1:0] CFG_START_STATE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_MASK = 1'b1;

  typedef logic [SET_W-1:0] set_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD_SYM = 2'd0,
    CMD_LOAD_EPS = 2'd1,
    CMD_BEGIN    = 2'd2,
    CMD_FEED     = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    OP_HOLD  = 2'd0,
    OP_LOAD  = 2'd1,
    OP_MERGE = 2'd2
  } unit_op_t;

  typedef struct packed {
    unit_op_t op;
    set_t     load_val;
    set_t     row;
    logic     gate;
    logic     clr_grew;
  } unit_ctl_t;

  typedef struct packed {
    logic              we;
    logic [SYM_AW-1:0] waddr;
    set_t              wdata;
    logic [SYM_AW-1:0] raddr;
  } sym_req_t;

  typedef struct packed {
    logic              we;
    logic [EPS_AW-1:0] waddr;
    set_t              wdata;
    logic [EPS_AW-1:0] raddr;
  } eps_req_t;

endpackage

/* design/nfaea_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfaea_in_if
// Input item channel: command, row address and target mask.
// ----------------------------------------------------------------------------
interface nfaea_in_if;
  import nfaea_pkg::*;

  logic                 valid;
  logic                 ready;
  cmd_t                 cmd;
  logic [ST_IDX_W-1:0]  state_index;
  logic [SYM_IDX_W-1:0] symbol;
  set_t                 target_mask;

  modport source (output valid, cmd, state_index, symbol, target_mask, input ready);
  modport sink   (input valid, cmd, state_index, symbol, target_mask, output ready);
endinterface

/* design/nfaea_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfaea_out_if
// Result item channel: accept flag, active set and empty flag.
// ----------------------------------------------------------------------------
interface nfaea_out_if;
  import nfaea_pkg::*;

  logic valid;
  logic ready;
  logic accepted;
  set_t active_set;
  logic dead;

  modport source (output valid, accepted, active_set, dead, input ready);
  modport sink   (input valid, accepted, active_set, dead, output ready);
endinterface

/* design/nfa_epsilon_acceptor.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfa_epsilon_acceptor
// Epsilon-NFA simulator over a set of active states, one item at a time.
// ----------------------------------------------------------------------------
// Load items write a symbol row or an epsilon row at the accepting edge and
// then go to the done state. Begin and feed items run on one shared OR
// accumulator that merges one table row a cycle from the row RAMs: a feed
// first scans the 16 symbol rows of the active states, then both begin and
// feed run epsilon closure passes, repeating until a pass adds no state;
// between 1 and 16 passes are run, set by the depth of the epsilon chains.
// The input is not ready while an item is at work; a finished result waits
// in the output register while the next item is taken, and an item that
// finishes while that register is still full holds in its last cycle until
// the result side takes the earlier result.
// Rows never written read back undefined.
// ----------------------------------------------------------------------------
module nfa_epsilon_acceptor (
  input  logic                              clk,
  input  logic                              rst_n,
  nfaea_in_if.sink                          in_ch,
  nfaea_out_if.source                       out_ch,
  input  logic                              cfg_we,
  input  logic [nfaea_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [nfaea_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import nfaea_pkg::*;

  logic [ST_IDX_W-1:0] start_state_r;
  set_t                accept_mask_r;

  sym_req_t  sym_req;
  eps_req_t  eps_req;
  set_t      sym_rdata;
  set_t      eps_rdata;
  unit_ctl_t unit_ctl;
  set_t      acc;
  logic      grew;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_state_r <= '0;
      accept_mask_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_START_STATE: start_state_r <= cfg_wdata[ST_IDX_W-1:0];
        CFG_ACCEPT_MASK: accept_mask_r <= cfg_wdata[SET_W-1:0];
        default: begin
          start_state_r <= start_state_r;
        end
      endcase
    end
  end

  nfaea_ram #(
    .WIDTH (SET_W),
    .DEPTH (SYM_DEPTH)
  ) u_sym_ram (
    .clk   (clk),
    .we    (sym_req.we),
    .waddr (sym_req.waddr),
    .wdata (sym_req.wdata),
    .raddr (sym_req.raddr),
    .rdata (sym_rdata)
  );

  nfaea_ram #(
    .WIDTH (SET_W),
    .DEPTH (EPS_DEPTH)
  ) u_eps_ram (
    .clk   (clk),
    .we    (eps_req.we),
    .waddr (eps_req.waddr),
    .wdata (eps_req.wdata),
    .raddr (eps_req.raddr),
    .rdata (eps_rdata)
  );

  nfaea_or_unit u_or_unit (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (unit_ctl),
    .acc   (acc),
    .grew  (grew)
  );

  nfaea_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .start_state (start_state_r),
    .accept_mask (accept_mask_r),
    .sym_req     (sym_req),
    .sym_rdata   (sym_rdata),
    .eps_req     (eps_req),
    .eps_rdata   (eps_rdata),
    .unit_ctl    (unit_ctl),
    .acc         (acc),
    .grew        (grew)
  );

endmodule

/* design/nfaea_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfaea_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module nfaea_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* design/nfaea_or_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfaea_or_unit
// Shared set accumulator: loads a set or merges one table row into it,
// and tracks whether the set grew during the current pass.
// ----------------------------------------------------------------------------
module nfaea_or_unit (
  input  logic                  clk,
  input  logic                  rst_n,
  input  nfaea_pkg::unit_ctl_t  ctl,
  output nfaea_pkg::set_t       acc,
  output logic                  grew
);
  import nfaea_pkg::*;

  set_t acc_r, acc_nxt;
  logic grew_r, grew_nxt;
  set_t merged;

  assign merged = acc_r | (ctl.row & STATE_MASK);

  always_comb begin
    acc_nxt  = acc_r;
    grew_nxt = grew_r;
    case (ctl.op)
      OP_LOAD: begin
        acc_nxt = ctl.load_val & STATE_MASK;
      end
      OP_MERGE: begin
        if (ctl.gate) begin
          acc_nxt = merged;
          if (merged != acc_r) begin
            grew_nxt = 1'b1;
          end
        end
      end
      default: begin
        acc_nxt = acc_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    if (!rst_n) begin
      grew_r <= 1'b0;
    end else if (ctl.clr_grew) begin
      grew_r <= 1'b0;
    end else begin
      grew_r <= grew_nxt;
    end
  end

  assign acc  = acc_r;
  // includes a merge happening this cycle
  assign grew = grew_nxt;

endmodule

/* design/nfaea_seq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfaea_seq
// Sequencer: decodes items, scans table rows through the RAMs, drives the
// shared accumulator and holds the active set and the result register.
// ----------------------------------------------------------------------------
module nfaea_seq (
  input  logic                            clk,
  input  logic                            rst_n,
  nfaea_in_if.sink                        in_ch,
  nfaea_out_if.source                     out_ch,
  input  logic [nfaea_pkg::ST_IDX_W-1:0]  start_state,
  input  nfaea_pkg::set_t                 accept_mask,
  output nfaea_pkg::sym_req_t             sym_req,
  input  nfaea_pkg::set_t                 sym_rdata,
  output nfaea_pkg::eps_req_t             eps_req,
  input  nfaea_pkg::set_t                 eps_rdata,
  output nfaea_pkg::unit_ctl_t            unit_ctl,
  input  nfaea_pkg::set_t                 acc,
  input  logic                            grew
);
  import nfaea_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SYM  = 4'b0010,
    S_EPS  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t               st_r, st_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 iss_r, iss_nxt;
  logic                 rdv_r;
  logic [CNT_W-1:0]     rdi_r;
  logic [SYM_IDX_W-1:0] sym_r, sym_nxt;
  logic                 upd_r, upd_nxt;
  set_t                 cur_r, cur_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_acc_r, out_acc_nxt;
  set_t                 out_set_r, out_set_nxt;
  logic                 out_dead_r, out_dead_nxt;

  logic in_take;
  logic last_data;
  logic sym_ok;
  logic ld_st_ok;
  logic ld_sym_ok;
  logic start_ok;
  set_t start_set;
  set_t fin_set;
  logic slot_free;

  assign in_ch.ready = (st_r == S_IDLE);
  assign in_take     = in_ch.valid && in_ch.ready;
  assign last_data   = rdv_r && (rdi_r == LAST_CNT);
  assign sym_ok      = (32'(sym_r) < NUM_SYMBOLS);
  assign ld_st_ok    = (32'(in_ch.state_index) < NUM_STATES);
  assign ld_sym_ok   = (32'(in_ch.symbol) < NUM_SYMBOLS);
  assign start_ok    = (32'(start_state) < LIVE_STATES);
  assign start_set   = start_ok ? (STATE_MASK & (set_t'(1) << start_state)) : '0;
  assign fin_set     = upd_r ? acc : cur_r;
  assign slot_free   = !out_valid_r || out_ch.ready;

  // table write ports, fed straight from the accepted item, and scan read addresses
  always_comb begin
    sym_req.we    = in_take && (in_ch.cmd == CMD_LOAD_SYM) && ld_st_ok && ld_sym_ok;
    sym_req.waddr = SYM_AW'(in_ch.state_index) * SYM_AW'(NUM_SYMBOLS)
                    + SYM_AW'(in_ch.symbol);
    sym_req.wdata = in_ch.target_mask & STATE_MASK;
    sym_req.raddr = SYM_AW'(cnt_r) * SYM_AW'(NUM_SYMBOLS) + SYM_AW'(sym_r);

    eps_req.we    = in_take && (in_ch.cmd == CMD_LOAD_EPS) && ld_st_ok;
    eps_req.waddr = EPS_AW'(in_ch.state_index);
    eps_req.wdata = in_ch.target_mask & STATE_MASK;
    eps_req.raddr = EPS_AW'(cnt_r);
  end

  always_comb begin
    st_nxt        = st_r;
    cnt_nxt       = cnt_r;
    iss_nxt       = iss_r;
    sym_nxt       = sym_r;
    upd_nxt       = upd_r;
    cur_nxt       = cur_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_acc_nxt   = out_acc_r;
    out_set_nxt   = out_set_r;
    out_dead_nxt  = out_dead_r;

    unit_ctl.op       = OP_HOLD;
    unit_ctl.load_val = '0;
    unit_ctl.row      = (st_r == S_SYM) ? sym_rdata : eps_rdata;
    unit_ctl.gate     = 1'b0;
    unit_ctl.clr_grew = 1'b0;

    // row address scan, one row a cycle
    if (iss_r) begin
      if (cnt_r == LAST_CNT) begin
        iss_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end

    unique case (st_r)
      S_IDLE: begin
        if (in_take) begin
          unique case (in_ch.cmd)
            CMD_LOAD_SYM, CMD_LOAD_EPS: begin
              upd_nxt = 1'b0;
              st_nxt  = S_DONE;
            end
            CMD_BEGIN: begin
              unit_ctl.op       = OP_LOAD;
              unit_ctl.load_val = start_set;
              unit_ctl.clr_grew = 1'b1;
              iss_nxt           = 1'b1;
              cnt_nxt           = '0;
              upd_nxt           = 1'b1;
              st_nxt            = S_EPS;
            end
            CMD_FEED: begin
              unit_ctl.op       = OP_LOAD;
              unit_ctl.load_val = '0;
              iss_nxt           = 1'b1;
              cnt_nxt           = '0;
              sym_nxt           = in_ch.symbol;
              upd_nxt           = 1'b1;
              st_nxt            = S_SYM;
            end
            default: begin
              st_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_SYM: begin
        if (rdv_r) begin
          unit_ctl.op   = OP_MERGE;
          unit_ctl.gate = sym_ok && cur_r[rdi_r];
        end
        if (last_data) begin
          unit_ctl.clr_grew = 1'b1;
          iss_nxt           = 1'b1;
          cnt_nxt           = '0;
          st_nxt            = S_EPS;
        end
      end
      S_EPS: begin
        // rows merge in place, so bits added earlier in the pass count
        if (rdv_r) begin
          unit_ctl.op   = OP_MERGE;
          unit_ctl.gate = acc[rdi_r];
        end
        if (last_data) begin
          if (grew) begin
            unit_ctl.clr_grew = 1'b1;
            iss_nxt           = 1'b1;
            cnt_nxt           = '0;
          end else begin
            st_nxt = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (slot_free) begin
          cur_nxt       = fin_set;
          out_valid_nxt = 1'b1;
          out_acc_nxt   = |(fin_set & accept_mask);
          out_set_nxt   = fin_set;
          out_dead_nxt  = (fin_set == '0);
          st_nxt        = S_IDLE;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      iss_r       <= 1'b0;
      rdv_r       <= 1'b0;
      upd_r       <= 1'b0;
      cur_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      iss_r       <= iss_nxt;
      rdv_r       <= iss_r;
      upd_r       <= upd_nxt;
      cur_r       <= cur_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cnt_r      <= cnt_nxt;
    rdi_r      <= cnt_r;
    sym_r      <= sym_nxt;
    out_acc_r  <= out_acc_nxt;
    out_set_r  <= out_set_nxt;
    out_dead_r <= out_dead_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.accepted   = out_acc_r;
  assign out_ch.active_set = out_set_r;
  assign out_ch.dead       = out_dead_r;

endmodule

/* tb/nfa_epsilon_acceptor_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfa_epsilon_acceptor_tb
// Fills the transition and epsilon tables, runs directed cases (load items,
// empty string, long epsilon chain, dead set), then random strings under
// several start/accept settings. Each result item is checked against an
// in-bench active-set predictor, with random gaps on both channels.
// ----------------------------------------------------------------------------
module nfa_epsilon_acceptor_tb;
  import nfaea_pkg::*;

  typedef struct packed {
    logic accepted;
    set_t active_set;
    logic dead;
  } nfa_result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  nfaea_in_if  in_ch ();
  nfaea_out_if out_ch ();

  nfa_epsilon_acceptor dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // predictor state
  set_t                sym_rows [SYM_DEPTH];
  set_t                eps_rows [EPS_DEPTH];
  set_t                active_now;
  logic [ST_IDX_W-1:0] start_reg;
  set_t                accept_reg;

  nfa_result_t pending_results[$];
  int unsigned errors;
  int unsigned items_sent;
  bit          in_idle;
  bit          out_idle;

  always #5 clk = ~clk;

  function automatic logic [ST_IDX_W-1:0] rand_state();
    return ST_IDX_W'($urandom_range(0, 15));
  endfunction

  function automatic logic [SYM_IDX_W-1:0] rand_symbol();
    return SYM_IDX_W'($urandom_range(0, 15));
  endfunction

  function automatic set_t epsilon_closure(set_t seed);
    set_t grown;
    set_t prev;
    bit   settled;
    grown   = seed & STATE_MASK;
    settled = 1'b0;
    for (int pass = 0; pass <= NUM_STATES && !settled; pass++) begin
      prev = grown;
      for (int s = 0; s < LIVE_STATES; s++) begin
        if (prev[s]) grown |= eps_rows[s];
      end
      grown &= STATE_MASK;
      settled = (grown == prev);
    end
    return grown;
  endfunction

  function automatic nfa_result_t next_nfa_result(cmd_t cmd, logic [ST_IDX_W-1:0] st,
                                                  logic [SYM_IDX_W-1:0] sym, set_t mask);
    nfa_result_t r;
    set_t        succ;
    succ = '0;
    case (cmd)
      CMD_LOAD_SYM: sym_rows[st * NUM_SYMBOLS + sym] = mask & STATE_MASK;
      CMD_LOAD_EPS: eps_rows[st] = mask & STATE_MASK;
      CMD_BEGIN: begin
        if (start_reg < LIVE_STATES) active_now = epsilon_closure(set_t'(1) << start_reg);
        else active_now = '0;
      end
      default: begin
        for (int s = 0; s < LIVE_STATES; s++) begin
          if (active_now[s]) succ |= sym_rows[s * NUM_SYMBOLS + sym];
        end
        active_now = epsilon_closure(succ);
      end
    endcase
    r.accepted   = (active_now & accept_reg) != '0;
    r.active_set = active_now;
    r.dead       = (active_now == '0);
    return r;
  endfunction

  function automatic set_t rand_mask();
    set_t m;
    case ($urandom_range(0, 7))
      0:       m = '0;
      1, 2, 3: m = set_t'(1) << $urandom_range(0, 15);
      4:       m = (set_t'(1) << $urandom_range(0, 15)) | (set_t'(1) << $urandom_range(0, 15));
      5:       m = set_t'($urandom & $urandom & $urandom);
      6:       m = set_t'($urandom);
      default: m = '1;
    endcase
    return m;
  endfunction

  // sparse epsilon rows give chains of a few hops rather than a full set
  function automatic set_t rand_eps_mask();
    set_t m;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: m = '0;
      5, 6, 7, 8:    m = set_t'(1) << $urandom_range(0, 15);
      default:       m = (set_t'(1) << $urandom_range(0, 15)) |
                         (set_t'(1) << $urandom_range(0, 15));
    endcase
    return m;
  endfunction

  function automatic void report_mismatch(string what, int unsigned want, int unsigned got);
    errors++;
    if (errors <= 10)
      $display("%0t mismatch on %s: expected 0x%0h, got 0x%0h", $realtime, what, want, got);
  endfunction

  // entered and left just after a falling edge
  task automatic send_item(cmd_t cmd, logic [ST_IDX_W-1:0] st, logic [SYM_IDX_W-1:0] sym,
                           set_t mask);
    int unsigned gap;
    gap = in_idle ? $urandom_range(0, 9) : 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.cmd         <= cmd;
    in_ch.state_index <= st;
    in_ch.symbol      <= sym;
    in_ch.target_mask <= mask;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_results.insert(pending_results.size(), next_nfa_result(cmd, st, sym, mask));
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_begin();
    send_item(CMD_BEGIN, rand_state(), rand_symbol(), set_t'($urandom));
  endtask

  task automatic send_feed(logic [SYM_IDX_W-1:0] sym);
    send_item(CMD_FEED, rand_state(), sym, set_t'($urandom));
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic set_config(logic [ST_IDX_W-1:0] start, set_t acc);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_START_STATE;
    cfg_wdata <= CFG_DATA_W'(start);
    @(negedge clk);
    cfg_idx   <= CFG_ACCEPT_MASK;
    cfg_wdata <= acc;
    @(negedge clk);
    cfg_we <= 1'b0;
    start_reg  = start;
    accept_reg = acc;
    @(negedge clk);
  endtask

  task automatic load_epsilon_rows();
    for (int s = 0; s < NUM_STATES; s++)
      send_item(CMD_LOAD_EPS, ST_IDX_W'(s), rand_symbol(), rand_eps_mask());
  endtask

  // every row written before any begin or feed can read it
  task automatic test_table_fill();
    for (int s = 0; s < NUM_STATES; s++) begin
      for (int y = 0; y < NUM_SYMBOLS; y++)
        send_item(CMD_LOAD_SYM, ST_IDX_W'(s), SYM_IDX_W'(y), rand_mask());
    end
    send_item(CMD_LOAD_SYM, 4'd0, 4'd0, '1);
    send_item(CMD_LOAD_SYM, 4'd15, 4'd15, '0);
    load_epsilon_rows();
  endtask

  // load items leave the active set alone
  task automatic test_load_keeps_set();
    send_begin();
    send_feed(4'd3);
    send_item(CMD_LOAD_SYM, 4'd15, 4'd0, '1);
    send_item(CMD_LOAD_EPS, 4'd0, 4'd15, '0);
    send_item(CMD_LOAD_SYM, 4'd0, 4'd15, 16'h5555);
    send_feed(4'd0);
  endtask

  // empty string: begin alone decides acceptance
  task automatic test_empty_string();
    send_item(CMD_LOAD_EPS, 4'd5, 4'd0, '0);
    set_config(4'd5, set_t'(1) << 5);
    send_begin();
    set_config(4'd5, '0);
    send_begin();
    set_config(4'd5, ~(set_t'(1) << 5));
    send_begin();
  endtask

  // deepest closure, then a dead set and feeding from it
  task automatic test_epsilon_chain();
    for (int s = 0; s < NUM_STATES; s++)
      send_item(CMD_LOAD_EPS, ST_IDX_W'(s), 4'd0,
                (s < NUM_STATES - 1) ? set_t'(1) << (s + 1) : '0);
    set_config(4'd0, 16'h8000);
    send_begin();
    set_config(4'd15, 16'h0001);
    send_begin();
    send_item(CMD_LOAD_SYM, 4'd15, 4'd9, '0);
    send_feed(4'd9);
    send_feed(4'd9);
    send_item(CMD_LOAD_SYM, 4'd15, 4'd0, 16'h0001);
    send_begin();
    send_feed(4'd0);
  endtask

  task automatic test_random_strings(logic [ST_IDX_W-1:0] start, set_t acc,
                                     int unsigned n_items);
    int unsigned stop_at;
    int unsigned len;
    set_config(start, acc);
    load_epsilon_rows();
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 7) == 0) begin
        in_idle  = $urandom_range(0, 2) != 0;
        out_idle = $urandom_range(0, 2) != 0;
      end
      case ($urandom_range(0, 9))
        0: send_item(cmd_t'($urandom_range(0, 3)), rand_state(), rand_symbol(), rand_mask());
        1: begin
          if ($urandom_range(0, 1) == 0)
            send_item(CMD_LOAD_SYM, rand_state(), rand_symbol(), rand_mask());
          else
            send_item(CMD_LOAD_EPS, rand_state(), rand_symbol(), rand_eps_mask());
        end
        default: begin
          send_begin();
          len = $urandom_range(0, 12);
          repeat (len) begin
            if ($urandom_range(0, 15) == 0)
              send_item(CMD_LOAD_SYM, rand_state(), rand_symbol(), rand_mask());
            send_feed(rand_symbol());
          end
        end
      endcase
    end
  endtask

  // result side: random stalls between result items
  initial begin : result_sink
    int unsigned stall;
    while (rst_n !== 1'b1) @(negedge clk);
    forever begin
      stall = out_idle ? $urandom_range(0, 9) : 0;
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin : result_check
    nfa_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t result item with nothing expected: set 0x%0h", $realtime,
                   out_ch.active_set);
      end else begin
        want = pending_results.pop_front();
        if (out_ch.accepted !== want.accepted)
          report_mismatch("accepted", want.accepted, out_ch.accepted);
        if (out_ch.active_set !== want.active_set)
          report_mismatch("active_set", want.active_set, out_ch.active_set);
        if (out_ch.dead !== want.dead)
          report_mismatch("dead", want.dead, out_ch.dead);
      end
    end
  end

  initial begin : watchdog
    #30_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : run
    clk               = 1'b0;
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_idx           = CFG_START_STATE;
    cfg_wdata         = '0;
    in_ch.valid       = 1'b0;
    in_ch.cmd         = CMD_LOAD_SYM;
    in_ch.state_index = '0;
    in_ch.symbol      = '0;
    in_ch.target_mask = '0;
    out_ch.ready      = 1'b0;
    errors            = 0;
    items_sent        = 0;
    in_idle           = 1'b1;
    out_idle          = 1'b1;
    active_now        = '0;
    start_reg         = '0;
    accept_reg        = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    set_config(4'd0, 16'h0001);
    test_table_fill();
    test_load_keeps_set();
    test_empty_string();
    test_epsilon_chain();
    test_random_strings(4'd0, '0, 220);
    test_random_strings(4'd15, '1, 220);
    test_random_strings(rand_state(), set_t'($urandom), 220);
    test_random_strings(4'd7, 16'h8001, 220);
    test_random_strings(rand_state(), set_t'(1) << $urandom_range(0, 15), 220);
    test_random_strings(rand_state(), set_t'($urandom), 220);

    wait_drained();
    repeat (40) @(negedge clk);
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end
endmodule

/* files.f */
design/nfaea_pkg.sv
design/nfaea_in_if.sv
design/nfaea_out_if.sv
design/nfaea_ram.sv
design/nfaea_or_unit.sv
design/nfaea_seq.sv
design/nfa_epsilon_acceptor.sv
tb/nfa_epsilon_acceptor_tb.sv
